// ===== rtl/tncm_pkg.sv =====
// ----------------------------------------------------------------------------
// tncm_pkg: shared types, constants and sine table math for the NCO mixer
// Register map, config bundle, defaults and the elaboration-time sine
// generator that fills the lookup ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tncm_pkg;

    localparam int PHASE_BITS            = 32;
    localparam int APB_ADDR_BITS         = 3;
    localparam int APB_DATA_BITS         = 32;
    localparam int DEF_TABLE_INDEX_BITS  = 12;
    localparam int DEF_SAMPLE_BITS       = 16;

    // register indexes (paddr[2])
    localparam logic REG_PHASE_INC = 1'b0;
    localparam logic REG_MIX_MODE  = 1'b1;

    localparam logic MIX_UP   = 1'b0;
    localparam logic MIX_DOWN = 1'b1;

    localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam longint unsigned ONE_Q62     = 64'h4000000000000000;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_increment;
        logic                  mix_down_mode;
    } tncm_cfg_t;

    // (a * b) >> 62, truncated, for a, b below 2^63
    function automatic longint unsigned mul_q62(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned ah, al, bh, bl, hh, hl, lh, ll, mid, high;
        ah   = a >> 32;
        al   = a & 64'hFFFF_FFFF;
        bh   = b >> 32;
        bl   = b & 64'hFFFF_FFFF;
        hh   = ah * bh;
        hl   = ah * bl;
        lh   = al * bh;
        ll   = al * bl;
        mid  = (ll >> 32) + (hl & 64'hFFFF_FFFF) + (lh & 64'hFFFF_FFFF);
        high = hh + (hl >> 32) + (lh >> 32) + (mid >> 32);
        return (high << 2) | ((mid & 64'hFFFF_FFFF) >> 30);
    endfunction

    // unsigned shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(x) in Q62 for x in [0, pi/2], Taylor series
    function automatic longint unsigned sin_q62(input longint unsigned x);
        longint unsigned x2, term, sum, div;
        logic            done;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        done = 1'b0;
        for (int n = 1; n < 40; n += 2) begin
            if (!done) begin
                div  = 64'(n + 1) * 64'(n + 2);
                term = udiv64(mul_q62(term, x2), div);
                if (term == 0) begin
                    done = 1'b1;
                end else if ((((n + 1) >> 1) & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // round(amplitude * sin(pi/2 * k / quarter)), half away from zero
    function automatic int quarter_value(input int k, input int index_bits,
                                         input int sample_bits);
        longint unsigned sh, x, s, amp, a, b, kk;
        sh  = 64'(index_bits - 2);
        kk  = 64'(k);
        amp = (64'd1 << (sample_bits - 1)) - 64'd1;
        x   = (HALF_PI_Q62 >> sh) * kk
            + (((HALF_PI_Q62 & ((64'd1 << sh) - 64'd1)) * kk) >> sh);
        s   = (k >= (1 << (index_bits - 2))) ? ONE_Q62 : sin_q62(x);
        a   = (s >> 31) * amp;
        b   = (s & 64'h7FFF_FFFF) * amp;
        return int'((a + (b >> 31) + (64'd1 << 30)) >> 31);
    endfunction

    // full-turn table entry i, built from one quarter wave
    function automatic int sine_entry(input int i, input int index_bits,
                                      input int sample_bits);
        int quad, k, qsize, v;
        qsize = 1 << (index_bits - 2);
        quad  = i >> (index_bits - 2);
        k     = i & (qsize - 1);
        v     = ((quad & 1) != 0) ? quarter_value(qsize - k, index_bits, sample_bits)
                                  : quarter_value(k, index_bits, sample_bits);
        return ((quad & 2) != 0) ? -v : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tncm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tncm_sine_rom: dual-read sine lookup ROM
// Constant table filled at elaboration, two read ports, registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tncm_sine_rom #(
    parameter int INDEX_BITS = tncm_pkg::DEF_TABLE_INDEX_BITS,
    parameter int DATA_BITS  = tncm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [INDEX_BITS-1:0]        sin_addr,
    input  logic [INDEX_BITS-1:0]        cos_addr,
    output logic signed [DATA_BITS-1:0]  sin_data,
    output logic signed [DATA_BITS-1:0]  cos_data
);
    import tncm_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    logic signed [DATA_BITS-1:0] rom_tab [DEPTH];
    logic signed [DATA_BITS-1:0] sin_data_reg;
    logic signed [DATA_BITS-1:0] cos_data_reg;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
        localparam int ENTRY = sine_entry(gi, INDEX_BITS, DATA_BITS);
        assign rom_tab[gi] = DATA_BITS'(ENTRY);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            sin_data_reg <= rom_tab[sin_addr];
            cos_data_reg <= rom_tab[cos_addr];
        end
    end

    assign sin_data = sin_data_reg;
    assign cos_data = cos_data_reg;

endmodule

`default_nettype wire

// ===== rtl/tncm_regs.sv =====
// ----------------------------------------------------------------------------
// tncm_regs: APB register file and phase accumulator
// Holds phase increment and mix direction; advances the phase once per
// accepted sample beat. Writing the increment clears the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tncm_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tncm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tncm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tncm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                advance,
    output tncm_pkg::tncm_cfg_t                 cfg,
    output logic [tncm_pkg::PHASE_BITS-1:0]     phase
);
    import tncm_pkg::*;

    logic [PHASE_BITS-1:0] phase_inc_reg;
    logic                  mix_mode_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  wr_en;
    logic                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= '0;
            mix_mode_reg  <= MIX_UP;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PHASE_INC: phase_inc_reg <= pwdata[PHASE_BITS-1:0];
                REG_MIX_MODE:  mix_mode_reg  <= pwdata[0];
                default:       mix_mode_reg  <= mix_mode_reg;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (wr_en && reg_idx == REG_PHASE_INC) begin
            phase_next = '0;
        end else if (advance) begin
            phase_next = phase_reg + phase_inc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PHASE_INC: prdata = APB_DATA_BITS'(phase_inc_reg);
            REG_MIX_MODE:  prdata = APB_DATA_BITS'(mix_mode_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.phase_increment = phase_inc_reg;
    assign cfg.mix_down_mode   = mix_mode_reg;
    assign phase               = phase_reg;

    a_inc_write_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && reg_idx == REG_PHASE_INC) |=> (phase_reg == '0))
        else $error("phase not cleared after increment write");

    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !wr_en) |=> (phase_reg == $past(phase_reg + phase_inc_reg)))
        else $error("phase did not advance by the increment");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

`default_nettype wire

// ===== rtl/tncm_mix.sv =====
// ----------------------------------------------------------------------------
// tncm_mix: complex multiply, round and saturate
// Stage 2 registers the four partial products, stage 3 sums, rounds
// (ties up), saturates and holds the result beat for the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module tncm_mix #(
    parameter int SAMPLE_BITS = tncm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sin_val,
    input  logic signed [SAMPLE_BITS-1:0] cos_val,
    input  logic signed [SAMPLE_BITS-1:0] in_real,
    input  logic signed [SAMPLE_BITS-1:0] in_imag,
    input  logic                          in_last,
    input  logic                          conj_mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_real,
    output logic signed [SAMPLE_BITS-1:0] out_imag,
    output logic                          out_last
);
    import tncm_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int SW = 2 * SAMPLE_BITS + 2;
    localparam int RW = SAMPLE_BITS + 3;
    localparam logic signed [SW-1:0] HALF  = SW'(64'd1 << (SAMPLE_BITS - 2));
    localparam logic signed [RW-1:0] R_MAX = RW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [SW-1:0] v);
        logic signed [SW-1:0] biased;
        logic signed [RW-1:0] r;
        biased = v + HALF;
        r      = RW'(biased >>> (SAMPLE_BITS - 1));
        if (r > R_MAX) begin
            r = R_MAX;
        end else if (r < R_MIN) begin
            r = R_MIN;
        end
        return SAMPLE_BITS'(r);
    endfunction

    logic                          v2_reg;
    logic                          v3_reg;
    logic                          en2;
    logic                          en3;
    logic signed [PW-1:0]          p_rc_reg;
    logic signed [PW-1:0]          p_is_reg;
    logic signed [PW-1:0]          p_rs_reg;
    logic signed [PW-1:0]          p_ic_reg;
    logic                          last2_reg;
    logic                          mode2_reg;
    logic signed [SW-1:0]          re_sum;
    logic signed [SW-1:0]          im_sum;
    logic signed [SAMPLE_BITS-1:0] re_next;
    logic signed [SAMPLE_BITS-1:0] im_next;
    logic signed [SAMPLE_BITS-1:0] re_reg;
    logic signed [SAMPLE_BITS-1:0] im_reg;
    logic                          last3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en2) begin
                v2_reg <= in_valid;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            p_rc_reg  <= in_real * cos_val;
            p_is_reg  <= in_imag * sin_val;
            p_rs_reg  <= in_real * sin_val;
            p_ic_reg  <= in_imag * cos_val;
            last2_reg <= in_last;
            mode2_reg <= conj_mode;
        end
    end

    always_comb begin
        if (mode2_reg == MIX_DOWN) begin
            re_sum = SW'(p_rc_reg) + SW'(p_is_reg);
            im_sum = SW'(p_ic_reg) - SW'(p_rs_reg);
        end else begin
            re_sum = SW'(p_rc_reg) - SW'(p_is_reg);
            im_sum = SW'(p_rs_reg) + SW'(p_ic_reg);
        end
        re_next = round_sat(re_sum);
        im_next = round_sat(im_sum);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            re_reg    <= re_next;
            im_reg    <= im_next;
            last3_reg <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_real  = re_reg;
    assign out_imag  = im_reg;
    assign out_last  = last3_reg;

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && en3) |=> v3_reg)
        else $error("product beat lost between stages");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !v3_reg |-> in_ready)
        else $error("mixer stalled with empty output register");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !en2) |=> (v2_reg && $stable(p_rc_reg) && $stable(p_ic_reg)))
        else $error("stalled product stage changed");

endmodule

`default_nettype wire

// ===== rtl/table_nco_complex_mixer.sv =====
// ----------------------------------------------------------------------------
// table_nco_complex_mixer: lookup-table NCO with complex mixer
// Reads sine/cosine from a quarter-wave-derived ROM at the phase accumulator,
// multiplies the sample by cos +/- j sin, rounds and saturates.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   tdata {in_imag, in_real}, tlast last_in
//   m_*       out  m_tvalid/m_tready   tdata {out_imag, out_real}, tlast last_out
//   apb       in   psel/penable        phase_increment @0x0, mix_down_mode @0x4
//
// One sample per clock while m_tready stays high; three register stages (ROM read
// and sample register, product register, result register), so m_tvalid rises
// once the beat reaches the result register.
// Synchronous active-low reset clears valids, config registers and the phase;
// the ROM is constant and needs no fill.
// Stalls ripple back stage by stage: a new beat is taken whenever the
// first stage is empty or moving, also while a result waits on m_tready
// as long as an earlier stage still has room.
// ----------------------------------------------------------------------------
`default_nettype none

module table_nco_complex_mixer #(
    parameter int TABLE_INDEX_BITS = tncm_pkg::DEF_TABLE_INDEX_BITS,
    parameter int SAMPLE_BITS      = tncm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // APB configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [tncm_pkg::APB_ADDR_BITS-1:0]          paddr,
    input  logic [tncm_pkg::APB_DATA_BITS-1:0]          pwdata,
    output logic [tncm_pkg::APB_DATA_BITS-1:0]          prdata,
    output logic                                        pready,
    // input samples
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // low to high: in_real, in_imag, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
    input  logic                                        s_tlast,
    // mixed samples
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // low to high: out_real, out_imag, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                        m_tlast
);
    import tncm_pkg::*;

    localparam int DATA_W   = 2 * SAMPLE_BITS;
    localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam logic [TABLE_INDEX_BITS-1:0] QUARTER_IDX =
        TABLE_INDEX_BITS'(1 << (TABLE_INDEX_BITS - 2));

    tncm_cfg_t                     cfg;
    logic [PHASE_BITS-1:0]         phase;
    logic                          s_accept;
    logic                          en1;
    logic                          mix_ready;
    logic                          v1_reg;
    logic signed [SAMPLE_BITS-1:0] real1_reg;
    logic signed [SAMPLE_BITS-1:0] imag1_reg;
    logic                          last1_reg;
    logic [TABLE_INDEX_BITS-1:0]   sin_idx;
    logic [TABLE_INDEX_BITS-1:0]   cos_idx;
    logic signed [SAMPLE_BITS-1:0] sin_val;
    logic signed [SAMPLE_BITS-1:0] cos_val;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;

    assign en1      = !v1_reg || mix_ready;
    assign s_tready = en1;
    assign s_accept = s_tvalid && s_tready;

    // cosine is a quarter turn ahead: add to the index, wraps naturally
    assign sin_idx = phase[PHASE_BITS-1 -: TABLE_INDEX_BITS];
    assign cos_idx = sin_idx + QUARTER_IDX;

    tncm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .advance (s_accept),
        .cfg     (cfg),
        .phase   (phase)
    );

    tncm_sine_rom #(
        .INDEX_BITS (TABLE_INDEX_BITS),
        .DATA_BITS  (SAMPLE_BITS)
    ) u_rom (
        .aclk     (aclk),
        .rd_en    (en1),
        .sin_addr (sin_idx),
        .cos_addr (cos_idx),
        .sin_data (sin_val),
        .cos_data (cos_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            real1_reg <= s_tdata[SAMPLE_BITS-1:0];
            imag1_reg <= s_tdata[DATA_W-1:SAMPLE_BITS];
            last1_reg <= s_tlast;
        end
    end

    tncm_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (mix_ready),
        .sin_val   (sin_val),
        .cos_val   (cos_val),
        .in_real   (real1_reg),
        .in_imag   (imag1_reg),
        .in_last   (last1_reg),
        .conj_mode (cfg.mix_down_mode),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .out_last  (m_tlast)
    );

    assign m_tdata = TDATA_W'({out_imag, out_real});

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> v1_reg)
        else $error("accepted beat missing from first stage");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !v1_reg) |-> s_tready)
        else $error("input not ready with empty pipeline");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lookup-table NCO complex mixer
// A directed table of corner samples and register settings runs first. Random
// samples then run through several phase-step and mix-mode settings under
// varied source gaps and sink back-pressure. Every output beat is compared
// with a typed expectation or an in-bench oscillator and mixer model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SW      = tncm_pkg::DEF_SAMPLE_BITS;
    localparam int TIB     = tncm_pkg::DEF_TABLE_INDEX_BITS;
    localparam int DW      = ((2*SW+7)/8)*8;
    localparam int AW      = tncm_pkg::APB_ADDR_BITS;
    localparam int LUT_LEN = 1 << TIB;
    localparam int QSIZE   = 1 << (TIB - 2);
    localparam int AMP     = (1 << (SW - 1)) - 1;
    localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< (SW - 1));
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam real HALF_PI  = 1.5707963267948966;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 175;
    localparam int NUM_PROBES     = 24;

    localparam logic [AW-1:0] ADDR_STEP = {tncm_pkg::REG_PHASE_INC, 2'b00};
    localparam logic [AW-1:0] ADDR_MODE = {tncm_pkg::REG_MIX_MODE, 2'b00};

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
    } mix_beat_t;

    // directed row: optional register update, then one sample
    typedef struct packed {
        logic                 set_regs;
        logic [31:0]          step;
        logic                 mode;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
        logic                 typed;
        logic signed [SW-1:0] want_re;
        logic signed [SW-1:0] want_im;
    } probe_row_t;

    localparam probe_row_t PROBES [NUM_PROBES] = '{
        // reset settings: phase stays 0, sin 0, cos full scale
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd0, 16'sd0, 1'b0, 1'b1, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd32767, 16'sd0, 1'b0, 1'b1, 16'sd32766, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sh8000, 16'sd0, 1'b1, 1'b1, -16'sd32767, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd0, 16'sd32767, 1'b0, 1'b1, 16'sd0, 16'sd32766},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd0, 16'sh8000, 1'b0, 1'b1, 16'sd0, -16'sd32767},
        // exact half-LSB ties round toward +inf
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd16384, -16'sd16384, 1'b1, 1'b1,
          16'sd16384, -16'sd16383},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, -16'sd16384, 16'sd16384, 1'b0, 1'b1,
          -16'sd16383, 16'sd16384},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd1, -16'sd1, 1'b0, 1'b1, 16'sd1, -16'sd1},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, -16'sd1, 16'sd1, 1'b1, 1'b1, -16'sd1, 16'sd1},
        // eighth-turn steps: saturation both ways, cosine wrap at 3/4 turn
        '{1'b1, 32'h2000_0000, tncm_pkg::MIX_UP, 16'sd32767, 16'sh8000, 1'b0, 1'b1,
          16'sd32766, -16'sd32767},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd32767, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd12345, -16'sd321, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_UP, 16'sd32767, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        // largest step: phase wraps below zero right away
        '{1'b1, 32'hFFFF_FFFF, tncm_pkg::MIX_DOWN, 16'sd32767, 16'sd32767, 1'b1, 1'b1,
          16'sd32766, 16'sd32766},
        '{1'b0, 32'h0, tncm_pkg::MIX_DOWN, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_DOWN, 16'sh8000, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b1, 32'h2000_0000, tncm_pkg::MIX_DOWN, 16'sh8000, 16'sh8000, 1'b0, 1'b1,
          -16'sd32767, -16'sd32767},
        '{1'b0, 32'h0, tncm_pkg::MIX_DOWN, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_DOWN, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 32'h0, tncm_pkg::MIX_DOWN, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0}
    };

    logic          aclk;
    logic          aresetn;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;    // low to high: in_real, in_imag, zero pad
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;    // low to high: out_real, out_imag, zero pad
    logic          m_tlast;

    table_nco_complex_mixer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // oscillator model state
    int          sine_lut [LUT_LEN];
    logic [31:0] nco_phase;
    logic [31:0] nco_step;
    logic        nco_mode;

    mix_beat_t expected_mix [$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int quarter_amp(input int k);
        if (k >= QSIZE) return AMP;
        return int'($floor(AMP * $sin(HALF_PI * real'(k) / real'(QSIZE)) + 0.5));
    endfunction

    function automatic logic signed [SW-1:0] scale_sat(input longint acc);
        longint r;
        r = (acc + (64'sd1 <<< (SW - 2))) >>> (SW - 1);
        if (r > SAT_HI) r = SAT_HI;
        else if (r < SAT_LO) r = SAT_LO;
        return r[SW-1:0];
    endfunction

    // mix one sample at the current phase, then advance the phase
    function automatic mix_beat_t nco_mix_step(input logic signed [SW-1:0] re_in,
                                               input logic signed [SW-1:0] im_in,
                                               input logic last_in);
        logic [31:0] cos_phase;
        longint      ar, ai, sv, cv, re_acc, im_acc;
        mix_beat_t   beat;
        cos_phase = nco_phase + QUARTER_TURN;
        ar = re_in;
        ai = im_in;
        sv = sine_lut[nco_phase >> (32 - TIB)];
        cv = sine_lut[cos_phase >> (32 - TIB)];
        if (nco_mode == tncm_pkg::MIX_DOWN) begin
            re_acc = ar * cv + ai * sv;
            im_acc = ai * cv - ar * sv;
        end else begin
            re_acc = ar * cv - ai * sv;
            im_acc = ar * sv + ai * cv;
        end
        beat.re   = scale_sat(re_acc);
        beat.im   = scale_sat(im_acc);
        beat.last = last_in;
        nco_phase = nco_phase + nco_step;
        return beat;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic apb_write(input logic [AW-1:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_mix.size() != 0) @(negedge aclk);
    endtask

    // step write also restarts the phase; upper mode bits are junk on purpose
    task automatic set_oscillator(input logic [31:0] step, input logic mode);
        logic [31:0] junk;
        wait_drained();
        junk = $urandom;
        apb_write(ADDR_STEP, step);
        nco_step  = step;
        nco_phase = '0;
        apb_write(ADDR_MODE, {junk[31:1], mode});
        nco_mode = mode;
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                               input logic last, input logic typed, input mix_beat_t typed_beat);
        mix_beat_t beat;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {{(DW-2*SW){1'b0}}, im, re};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        beat = nco_mix_step(re, im, last);
        expected_mix.push_back(typed ? typed_beat : beat);
        @(negedge aclk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(5))
                0: return 16'sh8000;
                1: return 16'sd32767;
                2: return 16'sd0;
                3: return -16'sd1;
                4: return 16'sd16384;
                default: return -16'sd16384;
            endcase
        end
        return r[SW-1:0];
    endfunction

    // sink: random stalls, plus a long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        mix_beat_t got;
        mix_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.re   = m_tdata[SW-1:0];
            got.im   = m_tdata[2*SW-1:SW];
            got.last = m_tlast;
            if (expected_mix.size() == 0) begin
                report_mismatch($sformatf("unexpected beat re=%0d im=%0d last=%0b",
                                          got.re, got.im, got.last));
            end else begin
                want = expected_mix.pop_front();
                if (got.re !== want.re)
                    report_mismatch($sformatf("out_real got %0d want %0d", got.re, want.re));
                if (got.im !== want.im)
                    report_mismatch($sformatf("out_imag got %0d want %0d", got.im, want.im));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int        i, ph, quad, k, v, n;
        logic [31:0] step;
        logic        mode;
        mix_beat_t   typed_beat;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        for (i = 0; i < LUT_LEN; i++) begin
            quad = i >> (TIB - 2);
            k    = i & (QSIZE - 1);
            v    = (quad & 1) ? quarter_amp(QSIZE - k) : quarter_amp(k);
            sine_lut[i] = (quad & 2) ? -v : v;
        end
        nco_phase = '0;
        nco_step  = '0;
        nco_mode  = tncm_pkg::MIX_UP;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < NUM_PROBES; i++) begin
            if (PROBES[i].set_regs) set_oscillator(PROBES[i].step, PROBES[i].mode);
            typed_beat.re   = PROBES[i].want_re;
            typed_beat.im   = PROBES[i].want_im;
            typed_beat.last = PROBES[i].last;
            send_sample(PROBES[i].re, PROBES[i].im, PROBES[i].last,
                        PROBES[i].typed, typed_beat);
        end

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin step = $urandom;      mode = tncm_pkg::MIX_UP;   end
                1: begin step = 32'hFFFF_FFFF; mode = tncm_pkg::MIX_DOWN; end
                2: begin step = 32'h0010_0000; mode = tncm_pkg::MIX_UP;   end
                3: begin step = $urandom;      mode = tncm_pkg::MIX_DOWN; end
                4: begin step = 32'h0;         mode = tncm_pkg::MIX_DOWN; end
                5: begin step = 32'h8000_0000; mode = tncm_pkg::MIX_UP;   end
                6: begin step = $urandom_range(32'h0010_0000); mode = tncm_pkg::MIX_DOWN; end
                default: begin step = $urandom; mode = tncm_pkg::MIX_UP; end
            endcase
            set_oscillator(step, mode);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 52; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            // sink holds off while the source keeps pushing: pipeline fills up
            if (ph == 0) hold_left = HOLD_CYCLES;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), pick_sample(), ($urandom_range(3) == 0),
                            1'b0, typed_beat);
        end

        wait_drained();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== table_nco_complex_mixer.f =====
rtl/tncm_pkg.sv
rtl/tncm_sine_rom.sv
rtl/tncm_regs.sv
rtl/tncm_mix.sv
rtl/table_nco_complex_mixer.sv
tb/tb_top.sv
